[hw/rtl/dcfs_pkg.sv]
// shared types, constants and crc function for the drive command frame sequencer
`default_nettype none

package dcfs_pkg;

  localparam int ActW  = 3;
  localparam int MmW   = 15;
  localparam int CfgW  = 16;
  localparam int PcW   = 4;
  localparam int ByteW = 3;

  localparam logic [ActW-1:0] ACT_MOVE     = 3'd0;
  localparam logic [ActW-1:0] ACT_ENABLE   = 3'd1;
  localparam logic [ActW-1:0] ACT_DISABLE  = 3'd2;
  localparam logic [ActW-1:0] ACT_SET_ZERO = 3'd3;
  localparam logic [ActW-1:0] ACT_ABORT    = 3'd4;

  localparam logic [2:0] CFG_DRIVE_ADDRESS  = 3'd0;
  localparam logic [2:0] CFG_LOWEST_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_HIGHEST_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_MOVE_SPEED     = 3'd3;
  localparam logic [2:0] CFG_ACCEL_TIME     = 3'd4;
  localparam logic [2:0] CFG_DECEL_TIME     = 3'd5;

  localparam logic [PcW-1:0] PC_MOVE     = 4'd0;
  localparam logic [PcW-1:0] PC_REJECT   = 4'd9;
  localparam logic [PcW-1:0] PC_ENABLE   = 4'd10;
  localparam logic [PcW-1:0] PC_DISABLE  = 4'd11;
  localparam logic [PcW-1:0] PC_SET_ZERO = 4'd12;
  localparam logic [PcW-1:0] PC_ABORT    = 4'd13;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;

  localparam logic [15:0] REG_CONTROL    = 16'h2000;
  localparam logic [15:0] REG_ZERO       = 16'h2002;
  localparam logic [15:0] REG_POS_MODE   = 16'h0A1E;
  localparam logic [15:0] REG_CMD_SOURCE = 16'h0A02;
  localparam logic [15:0] REG_SPEED      = 16'h0915;
  localparam logic [15:0] REG_ACCEL      = 16'h010E;
  localparam logic [15:0] REG_DECEL      = 16'h010F;
  localparam logic [15:0] REG_COUNT_LO   = 16'h0916;
  localparam logic [15:0] REG_COUNT_HI   = 16'h0917;
  localparam logic [15:0] REG_EXECUTE    = 16'h0919;

  // counts = 105263*mag + round(3*mag/19), the fraction via reciprocal of 38
  localparam logic [16:0] COUNT_WHOLE = 17'd105263;
  localparam logic [16:0] COUNT_REM   = 17'd6;
  localparam logic [16:0] COUNT_RND   = 17'd19;
  localparam logic [16:0] COUNT_RECIP = 17'd110377;
  localparam int          CountShift  = 22;

  typedef enum logic [1:0] {OP_FRAME, OP_CHECK, OP_REJECT} op_t;

  typedef enum logic [2:0] {
    VS_CONST, VS_SPEED, VS_ACCEL, VS_DECEL, VS_CNT_LO, VS_CNT_HI
  } vsel_t;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  typedef struct packed {
    op_t            op;
    logic [15:0]    reg_addr;
    vsel_t          vsel;
    logic [15:0]    cval;
    logic           last;
    logic [PcW-1:0] jmp;
  } cword_t;

  typedef struct packed {
    logic        emit;
    logic        reject;
    logic        last;
    logic [15:0] reg_addr;
    logic [15:0] value;
  } gen_ctl_t;

  typedef struct packed {
    logic adv;
    logic frame_done;
  } gen_sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/drive_command_frame_sequencer_unit.sv]
// top level: microcode sequencer, configuration registers and datapath
// first line byte: registered in the sequencer state, then in the output register;
//   a move runs its range check before it. commands are taken only while idle;
//   the frame generator gives one line byte per cycle while out_stall is low
// unused action codes are taken and dropped
// reset: registers to defaults, sequencer idle, no clearing pass
`default_nettype none

module drive_command_frame_sequencer_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [dcfs_pkg::ActW-1:0]         in_action,
  input  wire logic signed [dcfs_pkg::MmW-1:0]   in_target_height,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_tx_byte,
  output logic                                   out_frame_end,
  output logic                                   out_run_end,
  output logic                                   out_rejected,
  input  wire logic                              cfg_we,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [dcfs_pkg::CfgW-1:0]         cfg_wdata
);
  import dcfs_pkg::*;

  state_t         state_r, state_nxt;
  logic [PcW-1:0] pc_r, pc_nxt;
  cword_t         cw;
  gen_ctl_t       gen_ctl;
  gen_sts_t       gen_sts;

  logic [7:0]            addr_r;
  logic signed [MmW-1:0] low_r;
  logic signed [MmW-1:0] high_r;
  logic [15:0]           speed_r;
  logic [15:0]           accel_r;
  logic [15:0]           decel_r;
  logic signed [MmW-1:0] mm_r;

  logic        in_accept;
  logic        action_ok;
  logic        in_range;
  logic [31:0] count;
  logic [15:0] value;

  function automatic logic [PcW-1:0] entry_pc(input logic [ActW-1:0] a);
    logic [PcW-1:0] p;
    case (a)
      ACT_ENABLE:   p = PC_ENABLE;
      ACT_DISABLE:  p = PC_DISABLE;
      ACT_SET_ZERO: p = PC_SET_ZERO;
      ACT_ABORT:    p = PC_ABORT;
      default:      p = PC_MOVE;
    endcase
    return p;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign action_ok = (in_action <= ACT_ABORT);
  assign in_range  = (mm_r >= low_r) && (mm_r <= high_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= 8'd1;
      low_r   <= 15'sd0;
      high_r  <= 15'sd95;
      speed_r <= 16'd1000;
      accel_r <= 16'd100;
      decel_r <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRIVE_ADDRESS:  addr_r  <= cfg_wdata[7:0];
        CFG_LOWEST_HEIGHT:  low_r   <= cfg_wdata[MmW-1:0];
        CFG_HIGHEST_HEIGHT: high_r  <= cfg_wdata[MmW-1:0];
        CFG_MOVE_SPEED:     speed_r <= cfg_wdata;
        CFG_ACCEL_TIME:     accel_r <= cfg_wdata;
        CFG_DECEL_TIME:     decel_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mm_r <= in_target_height;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_comb begin
    case (cw.vsel)
      VS_SPEED:  value = speed_r;
      VS_ACCEL:  value = accel_r;
      VS_DECEL:  value = decel_r;
      VS_CNT_LO: value = count[15:0];
      VS_CNT_HI: value = count[31:16];
      default:   value = cw.cval;
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    pc_nxt           = pc_r;
    gen_ctl          = '0;
    gen_ctl.reg_addr = cw.reg_addr;
    gen_ctl.value    = value;
    gen_ctl.last     = cw.last;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && action_ok) begin
          state_nxt = S_RUN;
          pc_nxt    = entry_pc(in_action);
        end
      end
      S_RUN: begin
        unique case (cw.op)
          OP_CHECK: begin
            pc_nxt = in_range ? (pc_r + PcW'(1)) : cw.jmp;
          end
          OP_FRAME: begin
            gen_ctl.emit = 1'b1;
            if (gen_sts.frame_done) begin
              if (cw.last) begin
                state_nxt = S_IDLE;
              end else begin
                pc_nxt = pc_r + PcW'(1);
              end
            end
          end
          OP_REJECT: begin
            gen_ctl.reject = 1'b1;
            if (gen_sts.adv) begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  dcfs_rom u_rom (
    .pc (pc_r),
    .cw (cw)
  );

  dcfs_counts u_counts (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept && (in_action == ACT_MOVE)),
    .mm    (in_target_height),
    .count (count)
  );

  dcfs_frame_gen u_gen (
    .clk           (clk),
    .rst_n         (rst_n),
    .drive_address (addr_r),
    .ctl           (gen_ctl),
    .sts           (gen_sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end),
    .out_run_end   (out_run_end),
    .out_rejected  (out_rejected)
  );

  a_reject_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_run_end && !out_frame_end && (out_tx_byte == 8'h00))
    else $error("rejected item malformed");

  a_run_end_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_end && !out_rejected |-> out_frame_end)
    else $error("run end off a frame boundary");

  a_check_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && (cw.op == OP_CHECK) |=> (state_r == S_RUN))
    else $error("range check ended the run");

  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !gen_ctl.emit && !gen_ctl.reject)
    else $error("datapath driven while idle");

endmodule

`default_nettype wire

[hw/rtl/dcfs_rom.sv]
// microcode program rom of the frame sequencer
`default_nettype none

module dcfs_rom (
  input  wire logic [dcfs_pkg::PcW-1:0] pc,
  output dcfs_pkg::cword_t              cw
);
  import dcfs_pkg::*;

  always_comb begin
    cw = '{op: OP_REJECT, reg_addr: 16'h0000, vsel: VS_CONST, cval: 16'h0000,
           last: 1'b1, jmp: PC_REJECT};
    unique case (pc)
      PC_MOVE:     cw = '{OP_CHECK, 16'h0000, VS_CONST, 16'h0000, 1'b0, PC_REJECT};
      4'd1:        cw = '{OP_FRAME, REG_POS_MODE, VS_CONST, 16'h0003, 1'b0, PC_REJECT};
      4'd2:        cw = '{OP_FRAME, REG_CMD_SOURCE, VS_CONST, 16'h0000, 1'b0, PC_REJECT};
      4'd3:        cw = '{OP_FRAME, REG_SPEED, VS_SPEED, 16'h0000, 1'b0, PC_REJECT};
      4'd4:        cw = '{OP_FRAME, REG_ACCEL, VS_ACCEL, 16'h0000, 1'b0, PC_REJECT};
      4'd5:        cw = '{OP_FRAME, REG_DECEL, VS_DECEL, 16'h0000, 1'b0, PC_REJECT};
      4'd6:        cw = '{OP_FRAME, REG_COUNT_LO, VS_CNT_LO, 16'h0000, 1'b0, PC_REJECT};
      4'd7:        cw = '{OP_FRAME, REG_COUNT_HI, VS_CNT_HI, 16'h0000, 1'b0, PC_REJECT};
      4'd8:        cw = '{OP_FRAME, REG_EXECUTE, VS_CONST, 16'h0001, 1'b1, PC_REJECT};
      PC_REJECT:   cw = '{OP_REJECT, 16'h0000, VS_CONST, 16'h0000, 1'b1, PC_REJECT};
      PC_ENABLE:   cw = '{OP_FRAME, REG_CONTROL, VS_CONST, 16'h0008, 1'b1, PC_REJECT};
      PC_DISABLE:  cw = '{OP_FRAME, REG_CONTROL, VS_CONST, 16'h0003, 1'b1, PC_REJECT};
      PC_SET_ZERO: cw = '{OP_FRAME, REG_ZERO, VS_CONST, 16'h0001, 1'b1, PC_REJECT};
      PC_ABORT:    cw = '{OP_FRAME, REG_EXECUTE, VS_CONST, 16'h0000, 1'b1, PC_REJECT};
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/dcfs_counts.sv]
// millimetre to encoder count scaling, two register stages
`default_nettype none

module dcfs_counts (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [dcfs_pkg::MmW-1:0] mm,
  output logic [31:0]                      count
);
  import dcfs_pkg::*;

  logic [MmW-1:0] mag;
  logic [16:0]    frac_num;
  logic [30:0]    whole_prod;
  logic [33:0]    frac_prod;
  logic [31:0]    sum;

  logic [30:0] whole_r;
  logic [11:0] frac_r;
  logic        neg_r;
  logic        stage2_r;
  logic [31:0] count_r;

  always_comb begin
    mag        = mm[MmW-1] ? (~mm + MmW'(1)) : mm;
    frac_num   = {2'b00, mag} * COUNT_REM + COUNT_RND;
    whole_prod = {16'h0000, mag} * {14'h0000, COUNT_WHOLE};
    frac_prod  = {17'h00000, frac_num} * {17'h00000, COUNT_RECIP};
    sum        = {1'b0, whole_r} + {20'h00000, frac_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage2_r <= 1'b0;
    end else begin
      stage2_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      whole_r <= whole_prod;
      frac_r  <= frac_prod[CountShift +: 12];
      neg_r   <= mm[MmW-1];
    end
    if (stage2_r) begin
      count_r <= neg_r ? (32'h0 - sum) : sum;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

[hw/rtl/dcfs_frame_gen.sv]
// frame byte datapath with byte-wide crc and output register
`default_nettype none

module dcfs_frame_gen (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         drive_address,
  input  wire dcfs_pkg::gen_ctl_t ctl,
  output dcfs_pkg::gen_sts_t      sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_tx_byte,
  output logic                    out_frame_end,
  output logic                    out_run_end,
  output logic                    out_rejected
);
  import dcfs_pkg::*;

  localparam logic [ByteW-1:0] LastByte = 3'd7;
  localparam logic [ByteW-1:0] CrcLo    = 3'd6;

  logic             adv;
  logic             at_end;
  logic [7:0]       cur;
  logic [ByteW-1:0] byte_r;
  logic [15:0]      crc_r;
  logic             valid_r;
  logic [7:0]       tx_r;
  logic             fe_r;
  logic             re_r;
  logic             rej_r;

  assign adv    = !valid_r || !out_stall;
  assign at_end = (byte_r == LastByte);

  always_comb begin
    case (byte_r)
      3'd0:    cur = drive_address;
      3'd1:    cur = FUNC_WRITE_SINGLE;
      3'd2:    cur = ctl.reg_addr[15:8];
      3'd3:    cur = ctl.reg_addr[7:0];
      3'd4:    cur = ctl.value[15:8];
      3'd5:    cur = ctl.value[7:0];
      3'd6:    cur = crc_r[7:0];
      default: cur = crc_r[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      byte_r  <= '0;
      crc_r   <= CRC_INIT;
    end else if (adv) begin
      if (ctl.emit) begin
        valid_r <= 1'b1;
        byte_r  <= byte_r + ByteW'(1);
        if (at_end) begin
          crc_r <= CRC_INIT;
        end else if (byte_r < CrcLo) begin
          crc_r <= crc_byte(crc_r, cur);
        end
      end else begin
        valid_r <= ctl.reject;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r  <= ctl.emit ? cur : 8'h00;
      fe_r  <= ctl.emit && at_end;
      re_r  <= ctl.reject || (ctl.emit && ctl.last && at_end);
      rej_r <= ctl.reject;
    end
  end

  assign sts.adv        = adv;
  assign sts.frame_done = ctl.emit && adv && at_end;

  assign out_valid     = valid_r;
  assign out_tx_byte   = tx_r;
  assign out_frame_end = fe_r;
  assign out_run_end   = re_r;
  assign out_rejected  = rej_r;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// testbench for the drive command frame sequencer: predicts every line byte and checks it
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcfs_pkg::*;

  localparam logic [2:0]      CFG_SPARE_6   = 3'd6;
  localparam logic [2:0]      CFG_SPARE_7   = 3'd7;
  localparam logic [ActW-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ActW-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [ActW-1:0] ACT_SPARE_HI  = 3'd7;

  localparam logic [15:0] CTRL_ENABLE  = 16'h0008;
  localparam logic [15:0] CTRL_DISABLE = 16'h0003;
  localparam logic [15:0] ZERO_SET     = 16'h0001;
  localparam logic [15:0] EXEC_STOP    = 16'h0000;
  localparam logic [15:0] EXEC_START   = 16'h0001;
  localparam logic [15:0] POS_MODE_ABS = 16'h0003;
  localparam logic [15:0] CMD_SRC_BUS  = 16'h0000;

  localparam longint unsigned MM_COUNT_NUM = 64'd10000000;
  localparam longint unsigned MM_COUNT_DEN = 64'd95;

  localparam int SettleCycles = 8;
  localparam int MaxReports   = 10;
  localparam int DrainLimit   = 20000;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       run_end;
    logic       rejected;
  } line_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ActW-1:0]        in_action = '0;
  logic signed [MmW-1:0]  in_target_height = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_tx_byte;
  logic                   out_frame_end;
  logic                   out_run_end;
  logic                   out_rejected;
  logic                   cfg_we = 1'b0;
  logic [2:0]             cfg_index = '0;
  logic [CfgW-1:0]        cfg_wdata = '0;

  // register copies
  logic [7:0]            drv_addr = 8'd1;
  logic signed [MmW-1:0] lo_limit = 15'sd0;
  logic signed [MmW-1:0] hi_limit = 15'sd95;
  logic [15:0]           speed_cfg = 16'd1000;
  logic [15:0]           accel_ms = 16'd100;
  logic [15:0]           decel_ms = 16'd100;

  line_byte_t pending_bytes[$];

  int mismatches = 0;
  int n_commands = 0;
  int n_moves = 0;
  int n_rejects = 0;
  int n_ignored = 0;
  int n_bytes_checked = 0;
  int n_reg_writes = 0;

  int burst_left = 0;
  bit sender_gaps = 1'b1;
  int gap_max = 40;

  int hold_req = 0;
  int hold_left = 0;
  int stall_pct = 25;
  int stall_run_max = 3;
  int stall_run_left = 0;
  logic stall_now = 1'b0;

  drive_command_frame_sequencer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_target_height (in_target_height),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_byte      (out_tx_byte),
    .out_frame_end    (out_frame_end),
    .out_run_end      (out_run_end),
    .out_rejected     (out_rejected),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      fb = acc[0] ^ data[k];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic logic [31:0] height_to_counts(input logic signed [MmW-1:0] mm);
    int              mm_i;
    longint unsigned mag;
    longint unsigned q;
    mm_i = mm;
    mag = (mm_i < 0) ? longint'(-mm_i) : longint'(mm_i);
    q = (2 * mag * MM_COUNT_NUM + MM_COUNT_DEN) / (2 * MM_COUNT_DEN);
    return (mm_i < 0) ? 32'(-q) : 32'(q);
  endfunction

  function automatic void queue_frame(input logic [15:0] reg_addr, input logic [15:0] value,
                                      input logic closes_run);
    logic [7:0]  bytes [6];
    logic [15:0] crc;
    bytes = '{drv_addr, FUNC_WRITE_SINGLE, reg_addr[15:8], reg_addr[7:0],
              value[15:8], value[7:0]};
    crc = CRC_INIT;
    foreach (bytes[i]) begin
      crc = crc16_step(crc, bytes[i]);
      pending_bytes.push_back('{tx_byte: bytes[i], frame_end: 1'b0, run_end: 1'b0,
                                rejected: 1'b0});
    end
    pending_bytes.push_back('{tx_byte: crc[7:0], frame_end: 1'b0, run_end: 1'b0,
                              rejected: 1'b0});
    pending_bytes.push_back('{tx_byte: crc[15:8], frame_end: 1'b1, run_end: closes_run,
                              rejected: 1'b0});
  endfunction

  function automatic void predict_command(input logic [ActW-1:0] act,
                                          input logic signed [MmW-1:0] mm);
    logic [31:0] counts;
    if (act > ACT_ABORT) begin
      n_ignored++;
      return;
    end
    n_commands++;
    case (act)
      ACT_ENABLE:   queue_frame(REG_CONTROL, CTRL_ENABLE, 1'b1);
      ACT_DISABLE:  queue_frame(REG_CONTROL, CTRL_DISABLE, 1'b1);
      ACT_SET_ZERO: queue_frame(REG_ZERO, ZERO_SET, 1'b1);
      ACT_ABORT:    queue_frame(REG_EXECUTE, EXEC_STOP, 1'b1);
      default: begin
        n_moves++;
        if (mm < lo_limit || mm > hi_limit) begin
          n_rejects++;
          pending_bytes.push_back('{tx_byte: 8'h00, frame_end: 1'b0, run_end: 1'b1,
                                    rejected: 1'b1});
        end else begin
          counts = height_to_counts(mm);
          queue_frame(REG_POS_MODE, POS_MODE_ABS, 1'b0);
          queue_frame(REG_CMD_SOURCE, CMD_SRC_BUS, 1'b0);
          queue_frame(REG_SPEED, speed_cfg, 1'b0);
          queue_frame(REG_ACCEL, accel_ms, 1'b0);
          queue_frame(REG_DECEL, decel_ms, 1'b0);
          queue_frame(REG_COUNT_LO, counts[15:0], 1'b0);
          queue_frame(REG_COUNT_HI, counts[31:16], 1'b0);
          queue_frame(REG_EXECUTE, EXEC_START, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input line_byte_t want,
                                 input line_byte_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("%0t %s: exp %02h fe %0b re %0b rj %0b, got %02h fe %0b re %0b rj %0b",
               $time, what, want.tx_byte, want.frame_end, want.run_end, want.rejected,
               got.tx_byte, got.frame_end, got.run_end, got.rejected);
  endtask

  // receiver: random stall runs, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run_left == 0) begin
        stall_now = ($urandom_range(0, 99) < stall_pct);
        stall_run_left = $urandom_range(1, stall_run_max);
      end
      stall_run_left--;
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin : check_line
    line_byte_t want;
    line_byte_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{tx_byte: out_tx_byte, frame_end: out_frame_end, run_end: out_run_end,
              rejected: out_rejected};
      n_bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected item", '0, got);
      end else begin
        want = pending_bytes.pop_front();
        if (got !== want) report_mismatch("item mismatch", want, got);
      end
    end
  end

  task automatic send_command(input logic [ActW-1:0] act, input logic signed [MmW-1:0] mm);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (sender_gaps) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_target_height <= mm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(act, mm);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CfgW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_reg_writes++;
    case (idx)
      CFG_DRIVE_ADDRESS:  drv_addr = data[7:0];
      CFG_LOWEST_HEIGHT:  lo_limit = data[MmW-1:0];
      CFG_HIGHEST_HEIGHT: hi_limit = data[MmW-1:0];
      CFG_MOVE_SPEED:     speed_cfg = data;
      CFG_ACCEL_TIME:     accel_ms = data;
      CFG_DECEL_TIME:     decel_ms = data;
      default: ;
    endcase
  endtask

  task automatic test_reset_defaults();
    send_command(ACT_ENABLE, 15'sd0);
    send_command(ACT_DISABLE, 15'sd0);
    send_command(ACT_SET_ZERO, 15'sd0);
    send_command(ACT_ABORT, 15'sd0);
    send_command(ACT_MOVE, 15'sd0);
    send_command(ACT_MOVE, 15'sd95);
    send_command(ACT_MOVE, 15'sd96);
    send_command(ACT_MOVE, -15'sd1);
    send_command(ACT_SPARE_LO, 15'sd0);
    send_command(ACT_SPARE_MID, 15'sd0);
    send_command(ACT_SPARE_HI, 15'sd0);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_DRIVE_ADDRESS, 16'hA5F7);
    write_reg(CFG_LOWEST_HEIGHT, CfgW'(-10000));
    write_reg(CFG_HIGHEST_HEIGHT, 16'd10000);
    write_reg(CFG_MOVE_SPEED, 16'hFFFF);
    write_reg(CFG_ACCEL_TIME, 16'h0000);
    write_reg(CFG_DECEL_TIME, 16'hFFFF);
    write_reg(CFG_SPARE_6, 16'h1234);
    write_reg(CFG_SPARE_7, 16'hFFFF);
    send_command(ACT_MOVE, -15'sd10000);
    send_command(ACT_MOVE, 15'sd10000);
    send_command(ACT_MOVE, -15'sd1);
    send_command(ACT_MOVE, 15'sd1);
    wait_idle();
    // address above the valid slave range, limits at the field extremes
    write_reg(CFG_DRIVE_ADDRESS, 16'h00FF);
    write_reg(CFG_LOWEST_HEIGHT, 16'hC000);
    write_reg(CFG_HIGHEST_HEIGHT, 16'hBFFF);
    write_reg(CFG_MOVE_SPEED, 16'h0000);
    write_reg(CFG_ACCEL_TIME, 16'hFFFF);
    write_reg(CFG_DECEL_TIME, 16'h0000);
    send_command(ACT_MOVE, 15'sh4000);
    send_command(ACT_MOVE, 15'sh3FFF);
    send_command(ACT_ABORT, 15'sh7FFF);
    wait_idle();
    // crossed limits reject every move
    write_reg(CFG_DRIVE_ADDRESS, 16'h0000);
    write_reg(CFG_LOWEST_HEIGHT, 16'd5);
    write_reg(CFG_HIGHEST_HEIGHT, 16'd4);
    send_command(ACT_MOVE, 15'sd4);
    send_command(ACT_MOVE, 15'sd5);
    send_command(ACT_MOVE, 15'sd0);
    send_command(ACT_ENABLE, 15'sd0);
    wait_idle();
  endtask

  task automatic test_input_backpressure();
    write_reg(CFG_DRIVE_ADDRESS, 16'd17);
    write_reg(CFG_LOWEST_HEIGHT, 16'h4000);
    write_reg(CFG_HIGHEST_HEIGHT, 16'h3FFF);
    stall_pct = 0;
    sender_gaps = 1'b0;
    hold_req = 600;
    repeat (12) send_command(ACT_MOVE, MmW'($urandom));
    wait_idle();
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int                    counted;
    int                    r;
    int                    a;
    int                    b;
    int                    lo_i;
    int                    hi_i;
    logic [CfgW-1:0]       data;
    logic [ActW-1:0]       act;
    logic signed [MmW-1:0] mm;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_DRIVE_ADDRESS, CfgW'($urandom));
      case (phase % 3)
        0: begin
          a = $urandom_range(0, 20000) - 10000;
          b = $urandom_range(0, 20000) - 10000;
          lo_i = (a < b) ? a : b;
          hi_i = (a < b) ? b : a;
        end
        1: begin
          lo_i = -16384;
          hi_i = 16383;
        end
        default: begin
          a = $urandom_range(0, 19000) - 9500;
          lo_i = a - int'($urandom_range(0, 400));
          hi_i = a + int'($urandom_range(0, 400));
        end
      endcase
      data = CfgW'(lo_i);
      data[15] = $urandom_range(0, 1);
      write_reg(CFG_LOWEST_HEIGHT, data);
      data = CfgW'(hi_i);
      data[15] = $urandom_range(0, 1);
      write_reg(CFG_HIGHEST_HEIGHT, data);
      write_reg(CFG_MOVE_SPEED, CfgW'($urandom));
      write_reg(CFG_ACCEL_TIME, CfgW'($urandom));
      write_reg(CFG_DECEL_TIME, CfgW'($urandom));

      case (phase)
        0: begin stall_pct = 0;  stall_run_max = 1;  sender_gaps = 1'b0; end
        1: begin stall_pct = 20; stall_run_max = 3;  sender_gaps = 1'b1; gap_max = 5;  end
        2: begin stall_pct = 50; stall_run_max = 8;  sender_gaps = 1'b1; gap_max = 90; end
        3: begin stall_pct = 80; stall_run_max = 2;  sender_gaps = 1'b1; gap_max = 30; end
        4: begin stall_pct = 35; stall_run_max = 20; sender_gaps = 1'b1; gap_max = 70; end
        default: begin stall_pct = 0; stall_run_max = 1; sender_gaps = 1'b1; gap_max = 3; end
      endcase

      counted = 0;
      while (counted < 59) begin
        r = $urandom_range(0, 99);
        lo_i = lo_limit;
        hi_i = hi_limit;
        if (r < 55) begin
          act = ACT_MOVE;
          if (hi_i < lo_i) mm = MmW'($urandom);
          else if (r < 3) mm = lo_limit;
          else if (r < 6) mm = hi_limit;
          else mm = MmW'(lo_i + int'($urandom_range(0, hi_i - lo_i)));
        end else if (r < 65) begin
          act = ACT_MOVE;
          mm = MmW'($urandom);
        end else if (r < 94) begin
          act = ActW'($urandom_range(ACT_ENABLE, ACT_ABORT));
          mm = MmW'($urandom);
        end else begin
          act = ActW'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
          mm = MmW'($urandom);
        end
        send_command(act, mm);
        if (act <= ACT_ABORT) counted++;
      end
      wait_idle();
    end
    stall_pct = 25;
    stall_run_max = 3;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_input_backpressure();
    test_random_traffic();
    for (int g = 0; g < DrainLimit && pending_bytes.size() != 0; g++) @(posedge clk);
    repeat (2 * SettleCycles) @(posedge clk);
    $display("covered %0d commands, %0d moves (%0d rejected), %0d unused codes, %0d writes",
             n_commands, n_moves, n_rejects, n_ignored, n_reg_writes);
    $display("checked %0d line bytes, %0d mismatches, %0d still expected",
             n_bytes_checked, mismatches, pending_bytes.size());
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
